### src/ctt_pkg.sv
// ctt_pkg: shared types, codes and sizes for the countdown timer table.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctt_pkg;

   // Table size and derived widths
   localparam int POOL_DEPTH = 20;
   localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int SLOT_W     = 5;

   // Operation codes
   localparam logic [1:0] MODE_UPSERT = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   // Merge rules for an upsert that finds a match
   localparam logic [1:0] MERGE_APPEND = 2'd0;
   localparam logic [1:0] MERGE_SET    = 2'd1;
   localparam logic [1:0] MERGE_ADD    = 2'd2;

   // Result codes
   localparam logic [2:0] RES_UPDATED  = 3'd0;
   localparam logic [2:0] RES_INSERTED = 3'd1;
   localparam logic [2:0] RES_FULL     = 3'd2;
   localparam logic [2:0] RES_QUERY    = 3'd3;
   localparam logic [2:0] RES_HOOK     = 3'd4;
   localparam logic [2:0] RES_EXPIRE   = 3'd5;
   localparam logic [2:0] RES_DONE     = 3'd6;

   // Timer kinds with special handling
   localparam logic [7:0] KIND_HOOK_A  = 8'd1;
   localparam logic [7:0] KIND_HOOK_B  = 8'd2;
   localparam logic [7:0] KIND_EVENT_A = 8'd3;
   localparam logic [7:0] KIND_EVENT_B = 8'd4;

   // Shared unit operations
   localparam logic [1:0] ALU_PASS = 2'd0;
   localparam logic [1:0] ALU_ADD  = 2'd1;
   localparam logic [1:0] ALU_TICK = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         timer_kind;
      logic [15:0]        sub_ident;
      logic [1:0]         merge_rule;
      logic signed [31:0] timer_value;
      logic signed [15:0] tick_delta;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_type;
      logic [4:0]         slot;
      logic [7:0]         entry_kind;
      logic [15:0]        entry_sub;
      logic signed [31:0] entry_value;
      logic               flag;
      logic               last;
   } rsp_type;

   // One table entry as held in the memory
   typedef struct packed {
      logic [7:0]  kind;
      logic [15:0] sub;
      logic [31:0] value;
   } entry_type;

   // Control of the shared arithmetic unit
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] operand;
   } alu_ctl_type;

endpackage

`default_nettype wire

### src/ctt_alu.sv
// ctt_alu: shared adder/compare unit for the timer table sequencer.
// Depends on ctt_pkg (entry_type, alu_ctl_type, ALU_* codes).
`default_nettype none

module ctt_alu import ctt_pkg::*; (
   input  alu_ctl_type ctl,
   input  entry_type   ent,
   input  logic [7:0]  key_kind,
   input  logic [15:0] key_sub,
   output logic [31:0] result,
   output logic        match
);

   logic        sub_op;
   logic [31:0] b_eff;
   logic [31:0] sum;

   // One adder: add for merge, subtract for tick
   assign sub_op = (ctl.op == ALU_TICK);
   assign b_eff  = sub_op ? ~ctl.operand : ctl.operand;
   assign sum    = ent.value + b_eff + {31'd0, sub_op};

   // Key compare for the table search
   assign match = (ent.kind == key_kind) && (ent.sub == key_sub);

   // Result select; tick clamps zero or negative to zero
   always_comb begin
      case (ctl.op)
         ALU_ADD:  result = sum;
         ALU_TICK: result = ((sum == 32'd0) || sum[31]) ? 32'd0 : sum;
         default:  result = ctl.operand;
      endcase
   end

endmodule

`default_nettype wire

### src/ctt_rsp_reg.sv
// ctt_rsp_reg: output register for result beats, valid/stall handshake.
// Depends on ctt_pkg (rsp_type).
`default_nettype none

module ctt_rsp_reg import ctt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Room for a new beat when empty or when the held beat leaves now
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### src/countdown_timer_table_top.sv
// countdown_timer_table_top: timer table with sequencer, entry memory,
// shared arithmetic unit and output register. Depends on ctt_pkg, ctt_alu, ctt_rsp_reg.
// An upsert with the set or add rule, or a query, scans the table entry by
// entry (a registered memory read, then a key compare in the shared unit);
// an append upsert goes straight to the end of the table. A tick reads and
// evaluates each entry; an expired entry that is not the last is filled by
// moving the last entry into its slot, and a closing beat ends the walk.
// The single read port of the entry memory and the one shared adder set
// this pace. The sequencer waits while a beat is due and the result channel
// stalls. The block takes a new request only when the previous one has
// handed its last beat to the output register. Entries beyond the live
// count are never read, so the table needs no clearing after reset.
`default_nettype none

module countdown_timer_table_top import ctt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SRCH_RD   = 4'd1;
   localparam logic [3:0] ST_SRCH_CMP  = 4'd2;
   localparam logic [3:0] ST_QMISS     = 4'd3;
   localparam logic [3:0] ST_APPEND    = 4'd4;
   localparam logic [3:0] ST_TICK_RD   = 4'd5;
   localparam logic [3:0] ST_TICK_EVAL = 4'd6;
   localparam logic [3:0] ST_TICK_NEXT = 4'd7;
   localparam logic [3:0] ST_TICK_MV   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] live_m1;
   req_type          cmd_ff, cmd_in;
   logic             vzero_ff, vzero_in;

   // Entry memory, one write and one registered read port
   entry_type        mem [POOL_DEPTH];
   entry_type        rd_q_ff;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_ra, mem_wa;
   entry_type        mem_wd;

   alu_ctl_type      alu_ctl;
   logic [31:0]      alu_res;
   logic             alu_match;

   logic             rsp_ld, rsp_free;
   rsp_type          rsp_in;
   logic             want_beat;

   ctt_alu u_alu (
      .ctl      (alu_ctl),
      .ent      (rd_q_ff),
      .key_kind (cmd_ff.timer_kind),
      .key_sub  (cmd_ff.sub_ident),
      .result   (alu_res),
      .match    (alu_match)
   );

   ctt_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_ld),
      .load_data (rsp_in),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign live_m1   = live_ff - CNT_W'(1);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      live_in   = live_ff;
      cmd_in    = cmd_ff;
      vzero_in  = vzero_ff;
      mem_re    = 1'b0;
      mem_ra    = idx_ff[IDX_W-1:0];
      mem_we    = 1'b0;
      mem_wa    = idx_ff[IDX_W-1:0];
      mem_wd    = rd_q_ff;
      rsp_ld    = 1'b0;
      rsp_in    = '0;
      want_beat = 1'b0;
      alu_ctl.op      = ALU_PASS;
      alu_ctl.operand = cmd_ff.timer_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               idx_in = '0;
               case (req_data.mode)
                  MODE_UPSERT: begin
                     if (req_data.merge_rule inside {MERGE_SET, MERGE_ADD}) begin
                        state_in = ST_SRCH_RD;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  MODE_TICK:  state_in = ST_TICK_RD;
                  MODE_QUERY: state_in = ST_SRCH_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end

         // Search: read entry, then compare keys
         ST_SRCH_RD: begin
            if (idx_ff < live_ff) begin
               mem_re   = 1'b1;
               state_in = ST_SRCH_CMP;
            end else if (cmd_ff.mode == MODE_QUERY) begin
               state_in = ST_QMISS;
            end else begin
               state_in = ST_APPEND;
            end
         end

         ST_SRCH_CMP: begin
            if (alu_match) begin
               rsp_in.slot       = SLOT_W'(idx_ff);
               rsp_in.entry_kind = rd_q_ff.kind;
               rsp_in.entry_sub  = rd_q_ff.sub;
               rsp_in.last       = 1'b1;
               if (cmd_ff.mode == MODE_QUERY) begin
                  rsp_in.result_type = RES_QUERY;
                  rsp_in.entry_value = rd_q_ff.value;
                  rsp_in.flag        = 1'b1;
               end else begin
                  alu_ctl.op = (cmd_ff.merge_rule == MERGE_ADD) ? ALU_ADD : ALU_PASS;
                  rsp_in.result_type = RES_UPDATED;
                  rsp_in.entry_value = alu_res;
                  mem_wd.kind        = rd_q_ff.kind;
                  mem_wd.sub         = rd_q_ff.sub;
                  mem_wd.value       = alu_res;
               end
               if (rsp_free) begin
                  rsp_ld   = 1'b1;
                  mem_we   = (cmd_ff.mode != MODE_QUERY);
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SRCH_RD;
            end
         end

         ST_QMISS: begin
            rsp_in.result_type = RES_QUERY;
            rsp_in.entry_kind  = cmd_ff.timer_kind;
            rsp_in.entry_sub   = cmd_ff.sub_ident;
            rsp_in.last        = 1'b1;
            if (rsp_free) begin
               rsp_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // Append at the end of the table, or report full
         ST_APPEND: begin
            rsp_in.entry_kind  = cmd_ff.timer_kind;
            rsp_in.entry_sub   = cmd_ff.sub_ident;
            rsp_in.entry_value = cmd_ff.timer_value;
            rsp_in.last        = 1'b1;
            mem_wa             = live_ff[IDX_W-1:0];
            mem_wd.kind        = cmd_ff.timer_kind;
            mem_wd.sub         = cmd_ff.sub_ident;
            mem_wd.value       = cmd_ff.timer_value;
            if (live_ff < CNT_W'(POOL_DEPTH)) begin
               rsp_in.result_type = RES_INSERTED;
               rsp_in.slot        = SLOT_W'(live_ff);
               if (rsp_free) begin
                  mem_we  = 1'b1;
                  live_in = live_ff + CNT_W'(1);
               end
            end else begin
               rsp_in.result_type = RES_FULL;
            end
            if (rsp_free) begin
               rsp_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         // Tick walk
         ST_TICK_RD: begin
            if (idx_ff < live_ff) begin
               mem_re   = 1'b1;
               state_in = ST_TICK_EVAL;
            end else begin
               rsp_in.result_type = RES_DONE;
               rsp_in.last        = 1'b1;
               if (rsp_free) begin
                  rsp_ld   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_TICK_EVAL: begin
            alu_ctl.op      = ALU_TICK;
            alu_ctl.operand = {{16{cmd_ff.tick_delta[15]}}, cmd_ff.tick_delta};
            mem_we          = 1'b1;
            mem_wd.value    = alu_res;
            vzero_in        = (alu_res == 32'd0);
            want_beat       = (rd_q_ff.kind inside {KIND_HOOK_A, KIND_HOOK_B});
            rsp_in.result_type = RES_HOOK;
            rsp_in.slot        = SLOT_W'(idx_ff);
            rsp_in.entry_kind  = rd_q_ff.kind;
            rsp_in.entry_sub   = rd_q_ff.sub;
            rsp_in.entry_value = alu_res;
            if (!want_beat || rsp_free) begin
               rsp_ld   = want_beat;
               state_in = ST_TICK_NEXT;
            end
         end

         ST_TICK_NEXT: begin
            if (!vzero_ff) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_TICK_RD;
            end else begin
               want_beat = (rd_q_ff.kind inside {KIND_EVENT_A, KIND_EVENT_B});
               rsp_in.result_type = RES_EXPIRE;
               rsp_in.slot        = SLOT_W'(idx_ff);
               rsp_in.entry_kind  = rd_q_ff.kind;
               rsp_in.entry_sub   = rd_q_ff.sub;
               rsp_in.flag        = (rd_q_ff.kind == KIND_EVENT_A);
               if (!want_beat || rsp_free) begin
                  rsp_ld  = want_beat;
                  live_in = live_m1;
                  if (idx_ff == live_m1) begin
                     state_in = ST_TICK_RD;
                  end else begin
                     // fetch the last entry to fill the freed slot
                     mem_re   = 1'b1;
                     mem_ra   = live_m1[IDX_W-1:0];
                     state_in = ST_TICK_MV;
                  end
               end
            end
         end

         ST_TICK_MV: begin
            mem_we   = 1'b1;
            state_in = ST_TICK_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         live_ff  <= '0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cmd_ff   <= cmd_in;
      vzero_ff <= vzero_in;
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q_ff <= mem[mem_ra];
      end
   end

   // Checks
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(POOL_DEPTH))
      else $error("live count above table depth");

   a_no_beat_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsp_ld)
      else $error("result beat issued while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_ld && rsp_in.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after final beat");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ld |-> rsp_free)
      else $error("result beat loaded into full output register");

endmodule

`default_nettype wire
